FILE: sv/pdew_pkg.sv
// -----------------------------------------------------------------------------
// pdew_pkg
// Types, constants and arithmetic helpers of the degenerate edge weld block.
// -----------------------------------------------------------------------------
package pdew_pkg;

   localparam int DefaultMaxPoints = 32;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 24;

   localparam logic [CsrIdxW-1:0] CSR_DIST_SQ = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_SNAP_TOL = 1'd1;

   localparam logic [23:0] DIST_SQ_RESET = 24'd167772;
   localparam logic [11:0] SNAP_TOL_RESET = 12'd41;

   typedef struct packed {
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic signed [31:0] z_coord;
      logic               point_last;
   } pdew_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               point_present;
      logic               poly_valid;
      logic               overflow;
      logic               result_last;
   } pdew_rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } pdew_vtx_type;

   // Distance of a Q19.12 value to its nearest integer, in Q.12 units.
   function automatic logic [11:0] dist_to_int(logic signed [31:0] v);
      logic [11:0] f;
      logic [12:0] g;
      f = v[11:0];
      g = 13'd4096 - {1'b0, f};
      if (f == 12'd0) return 12'd0;
      return ({1'b0, f} < g) ? f : g[11:0];
   endfunction

   // Round half away from zero; results above the range saturate.
   function automatic logic signed [31:0] round_q12(logic signed [31:0] v);
      logic signed [32:0] r;
      logic               inc;
      r = {v[31], v[31:12], 12'd0};
      inc = v[31] ? (v[11:0] > 12'd2048) : (v[11:0] >= 12'd2048);
      if (inc) r = r + 33'sd4096;
      if (r > 33'sh0_7FFF_FFFF) r = 33'sh0_7FFF_FFFF;
      return r[31:0];
   endfunction

   function automatic logic signed [31:0] weld(logic signed [31:0] a,
                                               logic signed [31:0] b,
                                               logic [11:0] snap);
      logic signed [31:0] o;
      if (a[11:0] == 12'd0) o = a;
      else if (b[11:0] == 12'd0) o = b;
      else if (dist_to_int(a) < dist_to_int(b)) o = a;
      else o = b;
      if (dist_to_int(o) <= snap) o = round_q12(o);
      return o;
   endfunction

   function automatic logic [32:0] abs_diff(logic signed [31:0] a,
                                            logic signed [31:0] b);
      logic signed [32:0] d;
      d = {a[31], a} - {b[31], b};
      return d[32] ? 33'(-d) : 33'(d);
   endfunction

   // Short edge: no component apart by more than 1.0 and squared length below the threshold.
   function automatic logic degenerate(pdew_vtx_type a, pdew_vtx_type b, logic [23:0] thr);
      logic [32:0] mx, my, mz;
      logic [27:0] sum;
      mx = abs_diff(a.x, b.x);
      my = abs_diff(a.y, b.y);
      mz = abs_diff(a.z, b.z);
      sum = 28'(mx[12:0] * mx[12:0]) + 28'(my[12:0] * my[12:0])
          + 28'(mz[12:0] * mz[12:0]);
      if (mx > 33'd4096 || my > 33'd4096 || mz > 33'd4096) return 1'b0;
      return sum < {4'd0, thr};
   endfunction

endpackage

FILE: sv/pdew_ram.sv
// -----------------------------------------------------------------------------
// pdew_ram
// Generic single write, single read RAM with a registered read port.
// -----------------------------------------------------------------------------
module pdew_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: sv/polygon_degenerate_edge_weld_core.sv
// -----------------------------------------------------------------------------
// polygon_degenerate_edge_weld_core
// Stores a polygon, welds its short edges and streams out the cleaned vertices.
// -----------------------------------------------------------------------------
// Vertices load one per cycle while busy is low. The item with point_last set
// raises busy for one pass over the vertex memory: the first vertex is fetched,
// then each edge is checked, and after each weld the vertex after the removed
// one is fetched again, so a weld skips the removed vertex. A step that ends the
// scan follows, then each result is read and sent, and a closing state ends the
// pass. Results appear as one-cycle strobes on rsp_valid, never back to back,
// and cannot be held off. Vertices past MAX_POINTS are dropped and flag overflow
// on every result of the polygon.
module polygon_degenerate_edge_weld_core
   import pdew_pkg::*;
#(
   parameter int MAX_POINTS = DefaultMaxPoints
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  pdew_req_type        req_data,
   output logic                rsp_valid,
   output pdew_rsp_type        rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int IW = $clog2(MAX_POINTS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RDA, ST_LDA, ST_STEP, ST_EVAL, ST_ERD, ST_EOUT, ST_DONE
   } state_type;

   state_type    state_ff;
   logic [CW-1:0] count_ff, n0_ff, n_ff, r_ff, i_ff, k_ff;
   logic          ovf_ff, valid_ff;
   logic [23:0]   thr_ff;
   logic [11:0]   snap_ff;
   pdew_vtx_type  a_ff, slot0_ff;

   logic          accept, wrap, deg;
   logic [CW:0]   r_next1;
   pdew_vtx_type  b_vec, welded, rd_vtx, in_vtx;
   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [95:0]   wr_data, rd_data;

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept = start && !busy;
   assign in_vtx = '{x: req_data.x_coord, y: req_data.y_coord, z: req_data.z_coord};
   assign rd_vtx = rd_data;

   assign r_next1 = {1'b0, r_ff} + 1'b1;
   assign wrap = (r_next1 == {1'b0, n0_ff});
   assign b_vec = wrap ? ((i_ff == '0) ? a_ff : slot0_ff) : rd_vtx;
   assign deg = (n_ff != CW'(3)) && degenerate(a_ff, b_vec, thr_ff);
   assign welded = '{x: weld(a_ff.x, b_vec.x, snap_ff),
                     y: weld(a_ff.y, b_vec.y, snap_ff),
                     z: weld(a_ff.z, b_vec.z, snap_ff)};

   always_comb begin
      wr_en = 1'b0;
      wr_addr = i_ff[IW-1:0];
      wr_data = deg ? welded : a_ff;
      rd_en = 1'b0;
      rd_addr = r_ff[IW-1:0];
      case (state_ff)
         ST_IDLE: begin
            wr_en = accept && (count_ff < CW'(MAX_POINTS));
            wr_addr = count_ff[IW-1:0];
            wr_data = in_vtx;
         end
         ST_RDA: rd_en = 1'b1;
         ST_STEP: begin
            rd_en = 1'b1;
            rd_addr = r_next1[IW-1:0];
         end
         ST_EVAL: wr_en = !(deg && wrap);
         ST_ERD: begin
            rd_en = 1'b1;
            rd_addr = k_ff[IW-1:0];
         end
         default: ;
      endcase
   end

   pdew_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid <= 1'b0;
         thr_ff <= DIST_SQ_RESET;
         snap_ff <= SNAP_TOL_RESET;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_DIST_SQ: thr_ff <= csr_wdata;
               CSR_SNAP_TOL: snap_ff <= csr_wdata[11:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (count_ff < CW'(MAX_POINTS)) begin
                     count_ff <= count_ff + 1'b1;
                     n0_ff <= count_ff + 1'b1;
                     n_ff <= count_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                     n0_ff <= count_ff;
                     n_ff <= count_ff;
                  end
                  if (req_data.point_last) begin
                     r_ff <= '0;
                     i_ff <= '0;
                     valid_ff <= 1'b1;
                     state_ff <= ST_RDA;
                  end
               end
            end
            ST_RDA: state_ff <= ST_LDA;
            ST_LDA: begin
               a_ff <= rd_vtx;
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               if (r_ff >= n0_ff) begin
                  k_ff <= '0;
                  if (n_ff == '0) begin
                     // Everything was welded away: one empty result.
                     rsp_valid <= 1'b1;
                     rsp_data <= '{out_x: '0, out_y: '0, out_z: '0,
                                   point_present: 1'b0, poly_valid: 1'b0,
                                   overflow: ovf_ff, result_last: 1'b1};
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_ERD;
                  end
               end else begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               i_ff <= i_ff + 1'b1;
               if (deg) begin
                  valid_ff <= 1'b0;
                  n_ff <= n_ff - 1'b1;
                  if (wrap) begin
                     r_ff <= r_next1[CW-1:0];
                     state_ff <= ST_STEP;
                  end else begin
                     // The next vertex was removed; fetch the one after it.
                     if (i_ff == '0) slot0_ff <= welded;
                     r_ff <= r_ff + CW'(2);
                     state_ff <= ST_RDA;
                  end
               end else begin
                  if (i_ff == '0) slot0_ff <= a_ff;
                  a_ff <= b_vec;
                  r_ff <= r_next1[CW-1:0];
                  state_ff <= ST_STEP;
               end
            end
            ST_ERD: state_ff <= ST_EOUT;
            ST_EOUT: begin
               rsp_valid <= 1'b1;
               rsp_data <= '{out_x: rd_vtx.x, out_y: rd_vtx.y, out_z: rd_vtx.z,
                             point_present: 1'b1,
                             poly_valid: valid_ff && (n_ff >= CW'(3)),
                             overflow: ovf_ff,
                             result_last: (k_ff + 1'b1 == n_ff)};
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff + 1'b1 == n_ff) ? ST_DONE : ST_ERD;
            end
            ST_DONE: begin
               count_ff <= '0;
               ovf_ff <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: sv/pdew_checker.sv
// -----------------------------------------------------------------------------
// pdew_checker
// Port level checks of the weld core, bound to the top level.
// -----------------------------------------------------------------------------
module pdew_checker
   import pdew_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input pdew_req_type req_data,
   input logic         rsp_valid,
   input pdew_rsp_type rsp_data
);

   // A result only appears while a polygon is being processed.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside of a polygon pass");

   // Results of one polygon are never adjacent.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back results");

   // A final vertex transfer starts a pass.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.point_last) |=> busy)
      else $error("final vertex did not start a pass");

   // An empty result is always the last of its polygon.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.point_present) |-> rsp_data.result_last)
      else $error("empty result not marked last");

endmodule

bind polygon_degenerate_edge_weld_core pdew_checker u_pdew_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
